[src/hsr_pkg.sv]
`default_nettype none

package hsr_pkg;

   localparam int PENDING_DEPTH = 4;
   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int IDX_W = $clog2(PENDING_DEPTH);

   localparam int KEY_W = 7;
   localparam int CODE_W = 8;
   localparam int KIND_W = 2;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODIFIER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREV_KEY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEXT_KEY = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MENU_KEY = 2'd3;

   localparam logic [KEY_W-1:0] MODIFIER_RESET = 7'h38;
   localparam logic [KEY_W-1:0] PREV_KEY_RESET = 7'h02;
   localparam logic [KEY_W-1:0] NEXT_KEY_RESET = 7'h03;
   localparam logic [KEY_W-1:0] MENU_KEY_RESET = 7'h29;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_FWD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PREV = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEXT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MENU = 2'd3;

   // outcome of matching one scancode
   localparam logic [1:0] OUTC_HOLD = 2'd0;
   localparam logic [1:0] OUTC_CMD  = 2'd1;
   localparam logic [1:0] OUTC_MISS = 2'd2;

   typedef struct packed {
      logic take;
      logic emit_cmd;
      logic replay_step;
   } hsr_cmd_type;

   typedef struct packed {
      logic [1:0] outcome;
      logic       replay_last;
      logic       slot_free;
   } hsr_status_type;

endpackage

`default_nettype wire

[src/hsr_if.sv]
`default_nettype none

interface hsr_req_if;
   logic                        valid;
   logic                        ready;
   logic [hsr_pkg::CODE_W-1:0]  scancode;
   modport source (output valid, output scancode, input ready);
   modport sink (input valid, input scancode, output ready);
endinterface

interface hsr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hsr_pkg::KIND_W-1:0]  kind;
   logic [hsr_pkg::CODE_W-1:0]  code;
   logic                        last;
   modport source (output valid, output kind, output code, output last, input ready);
   modport sink (input valid, input kind, input code, input last, output ready);
endinterface

interface hsr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [hsr_pkg::CSR_IDX_W-1:0]  index;
   logic [hsr_pkg::KEY_W-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/hsr_ctrl.sv]
`default_nettype none

module hsr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  hsr_pkg::hsr_status_type status,
   output hsr_pkg::hsr_cmd_type    cmd
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_REPLAY = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.slot_free;
            if (req_valid && status.slot_free) begin
               cmd.take = 1'b1;
               if (status.outcome == hsr_pkg::OUTC_CMD) begin
                  cmd.emit_cmd = 1'b1;
               end else if (status.outcome == hsr_pkg::OUTC_MISS) begin
                  state_in = ST_REPLAY;
               end
            end
         end
         ST_REPLAY: begin
            if (status.slot_free) begin
               cmd.replay_step = 1'b1;
               if (status.replay_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // no new transaction while pending codes are being replayed
   a_no_take_in_replay: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REPLAY |-> !req_ready && !cmd.take)
      else $error("input taken during replay");

   a_replay_after_miss: assert property (@(posedge clock) disable iff (reset)
      cmd.take && status.outcome == hsr_pkg::OUTC_MISS |=> state_ff == ST_REPLAY)
      else $error("mismatch did not start replay");
`endif

endmodule

`default_nettype wire

[src/hsr_dpath.sv]
`default_nettype none

module hsr_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hsr_pkg::CODE_W-1:0]    req_scancode,
   input  logic                          csr_write,
   input  logic [hsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hsr_pkg::KEY_W-1:0]     csr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [hsr_pkg::KIND_W-1:0]    rsp_kind,
   output logic [hsr_pkg::CODE_W-1:0]    rsp_code,
   output logic                          rsp_last,
   input  hsr_pkg::hsr_cmd_type          cmd,
   output hsr_pkg::hsr_status_type       status
);

   localparam logic [2:0] MS_START   = 3'd0;
   localparam logic [2:0] MS_CONTEXT = 3'd1;
   localparam logic [2:0] MS_PREV    = 3'd2;
   localparam logic [2:0] MS_NEXT    = 3'd3;
   localparam logic [2:0] MS_MENU    = 3'd4;
   localparam logic [2:0] MS_PREV_UP = 3'd5;
   localparam logic [2:0] MS_NEXT_UP = 3'd6;
   localparam logic [2:0] MS_MENU_UP = 3'd7;

   logic [hsr_pkg::KEY_W-1:0] modifier_ff;
   logic [hsr_pkg::KEY_W-1:0] prev_key_ff;
   logic [hsr_pkg::KEY_W-1:0] next_key_ff;
   logic [hsr_pkg::KEY_W-1:0] menu_key_ff;

   logic [2:0]                match_state_ff;
   logic [2:0]                match_state_in;
   logic [hsr_pkg::CNT_W-1:0] pending_count_ff;
   logic [hsr_pkg::IDX_W-1:0] replay_idx_ff;
   logic [hsr_pkg::CODE_W-1:0] pending_ff [hsr_pkg::PENDING_DEPTH];

   logic                       rsp_valid_ff;
   logic [hsr_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [hsr_pkg::CODE_W-1:0] rsp_code_ff;
   logic                       rsp_last_ff;

   logic [1:0]                 outcome;
   logic [hsr_pkg::KIND_W-1:0] cmd_kind;
   logic                       buf_full;
   logic                       replay_last;
   logic [hsr_pkg::CNT_W-1:0]  replay_pos;
   logic                       slot_free;

   // matching against the current scancode
   always_comb begin
      match_state_in = MS_START;
      outcome = hsr_pkg::OUTC_MISS;
      cmd_kind = hsr_pkg::KIND_FWD;
      case (match_state_ff)
         MS_START: begin
            if (req_scancode == {1'b0, modifier_ff}) begin
               match_state_in = MS_CONTEXT;
               outcome = hsr_pkg::OUTC_HOLD;
            end
         end
         MS_CONTEXT: begin
            if (req_scancode == {1'b0, prev_key_ff}) begin
               match_state_in = MS_PREV;
               outcome = hsr_pkg::OUTC_HOLD;
            end else if (req_scancode == {1'b0, next_key_ff}) begin
               match_state_in = MS_NEXT;
               outcome = hsr_pkg::OUTC_HOLD;
            end else if (req_scancode == {1'b0, menu_key_ff}) begin
               match_state_in = MS_MENU;
               outcome = hsr_pkg::OUTC_HOLD;
            end
         end
         MS_PREV: begin
            if (req_scancode == {1'b1, prev_key_ff}) begin
               match_state_in = MS_PREV_UP;
               outcome = hsr_pkg::OUTC_HOLD;
            end
         end
         MS_NEXT: begin
            if (req_scancode == {1'b1, next_key_ff}) begin
               match_state_in = MS_NEXT_UP;
               outcome = hsr_pkg::OUTC_HOLD;
            end
         end
         MS_MENU: begin
            if (req_scancode == {1'b1, menu_key_ff}) begin
               match_state_in = MS_MENU_UP;
               outcome = hsr_pkg::OUTC_HOLD;
            end
         end
         MS_PREV_UP: begin
            if (req_scancode == {1'b1, modifier_ff}) begin
               outcome = hsr_pkg::OUTC_CMD;
               cmd_kind = hsr_pkg::KIND_PREV;
            end
         end
         MS_NEXT_UP: begin
            if (req_scancode == {1'b1, modifier_ff}) begin
               outcome = hsr_pkg::OUTC_CMD;
               cmd_kind = hsr_pkg::KIND_NEXT;
            end
         end
         MS_MENU_UP: begin
            if (req_scancode == {1'b1, modifier_ff}) begin
               outcome = hsr_pkg::OUTC_CMD;
               cmd_kind = hsr_pkg::KIND_MENU;
            end
         end
         default: begin
            outcome = hsr_pkg::OUTC_MISS;
         end
      endcase
   end

   assign buf_full = (pending_count_ff == hsr_pkg::CNT_W'(hsr_pkg::PENDING_DEPTH));
   assign replay_pos = hsr_pkg::CNT_W'(replay_idx_ff) + hsr_pkg::CNT_W'(1);
   assign replay_last = (replay_pos == pending_count_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign status.outcome = outcome;
   assign status.replay_last = replay_last;
   assign status.slot_free = slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         modifier_ff <= hsr_pkg::MODIFIER_RESET;
         prev_key_ff <= hsr_pkg::PREV_KEY_RESET;
         next_key_ff <= hsr_pkg::NEXT_KEY_RESET;
         menu_key_ff <= hsr_pkg::MENU_KEY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            hsr_pkg::CSR_MODIFIER: modifier_ff <= csr_data;
            hsr_pkg::CSR_PREV_KEY: prev_key_ff <= csr_data;
            hsr_pkg::CSR_NEXT_KEY: next_key_ff <= csr_data;
            hsr_pkg::CSR_MENU_KEY: menu_key_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // pending buffer, no reset: only entries below the count are read
   always_ff @(posedge clock) begin
      if (cmd.take && !buf_full) begin
         pending_ff[pending_count_ff[hsr_pkg::IDX_W-1:0]] <= req_scancode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_state_ff <= MS_START;
         pending_count_ff <= '0;
         replay_idx_ff <= '0;
      end else begin
         if (cmd.take) begin
            match_state_ff <= match_state_in;
            if (cmd.emit_cmd) begin
               pending_count_ff <= '0;
            end else if (!buf_full) begin
               pending_count_ff <= pending_count_ff + hsr_pkg::CNT_W'(1);
            end
         end
         if (cmd.replay_step) begin
            if (replay_last) begin
               replay_idx_ff <= '0;
               pending_count_ff <= '0;
            end else begin
               replay_idx_ff <= replay_idx_ff + hsr_pkg::IDX_W'(1);
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_cmd || cmd.replay_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_cmd) begin
         rsp_kind_ff <= cmd_kind;
         rsp_code_ff <= '0;
         rsp_last_ff <= 1'b1;
      end else if (cmd.replay_step) begin
         rsp_kind_ff <= hsr_pkg::KIND_FWD;
         rsp_code_ff <= pending_ff[replay_idx_ff];
         rsp_last_ff <= replay_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_code = rsp_code_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_partial_match_has_codes: assert property (@(posedge clock) disable iff (reset)
      match_state_ff != MS_START |-> pending_count_ff != '0)
      else $error("partial match with empty pending buffer");

   a_cmd_clears_buffer: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_cmd |=> rsp_valid_ff && rsp_last_ff && pending_count_ff == '0)
      else $error("switch command did not clear pending codes");
`endif

endmodule

`default_nettype wire

[src/hotkey_sequence_recognizer.sv]
// a scancode that keeps a sequence alive gives no result;
// a completed sequence shows its switch command in the cycle after the transaction.
// on a mismatch the pending codes (one to four) leave one per cycle while the output is not
// stalled; the replay sequencer blocks input meanwhile.
// synchronous active-high reset restores the default key codes and empties the buffer.
`default_nettype none

module hotkey_sequence_recognizer (
   input  logic          clock,
   input  logic          reset,
   hsr_req_if.sink       req_chan,
   hsr_rsp_if.source     rsp_chan,
   hsr_csr_if.sink       csr_chan
);

   hsr_pkg::hsr_cmd_type    cmd;
   hsr_pkg::hsr_status_type status;
   logic                    csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write = csr_chan.valid;

   hsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hsr_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_scancode (req_chan.scancode),
      .csr_write    (csr_write),
      .csr_index    (csr_chan.index),
      .csr_data     (csr_chan.data),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_kind     (rsp_chan.kind),
      .rsp_code     (rsp_chan.code),
      .rsp_last     (rsp_chan.last),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

`default_nettype wire

[tb/sv/hotkey_checker.sv]
module hotkey_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [hsr_pkg::CODE_W-1:0]       req_scancode,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [hsr_pkg::KIND_W-1:0]       rsp_kind,
   input  logic [hsr_pkg::CODE_W-1:0]       rsp_code,
   input  logic                             rsp_last,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [hsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsr_pkg::KEY_W-1:0]        csr_data,
   output int                               error_count,
   output int                               pending_results,
   output int                               scancodes_seen,
   output int                               commands_seen,
   output int                               forwards_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_MOD_DOWN, SEQ_PREV_DOWN, SEQ_NEXT_DOWN, SEQ_MENU_DOWN,
      SEQ_PREV_UP, SEQ_NEXT_UP, SEQ_MENU_UP
   } hotkey_state_type;

   typedef struct packed {
      logic [hsr_pkg::KIND_W-1:0] kind;
      logic [hsr_pkg::CODE_W-1:0] code;
      logic                       last;
   } hotkey_result_type;

   logic [hsr_pkg::KEY_W-1:0]  mod_key, prev_key, next_key, menu_key;
   hotkey_state_type           seq_state;
   logic [hsr_pkg::CODE_W-1:0] held_codes [hsr_pkg::PENDING_DEPTH];
   int                         held_count;
   hotkey_result_type          expected_results [$];

   initial begin
      error_count = 0;
      pending_results = 0;
      scancodes_seen = 0;
      commands_seen = 0;
      forwards_seen = 0;
   end

   // works out what one accepted scancode produces and advances the matcher
   task automatic track_scancode(input logic [hsr_pkg::CODE_W-1:0] sc);
      hotkey_state_type           next_state;
      logic [hsr_pkg::KIND_W-1:0] cmd_kind;
      logic                       alive;
      logic                       done;
      hotkey_result_type          res;
      int                         i;
      next_state = seq_state;
      cmd_kind = hsr_pkg::KIND_FWD;
      alive = 1'b1;
      done = 1'b0;
      if (held_count < hsr_pkg::PENDING_DEPTH) begin
         held_codes[held_count] = sc;
         held_count++;
      end
      case (seq_state)
         SEQ_IDLE:
            if (sc == {1'b0, mod_key}) next_state = SEQ_MOD_DOWN;
            else alive = 1'b0;
         SEQ_MOD_DOWN:
            if (sc == {1'b0, prev_key}) next_state = SEQ_PREV_DOWN;
            else if (sc == {1'b0, next_key}) next_state = SEQ_NEXT_DOWN;
            else if (sc == {1'b0, menu_key}) next_state = SEQ_MENU_DOWN;
            else alive = 1'b0;
         SEQ_PREV_DOWN:
            if (sc == {1'b1, prev_key}) next_state = SEQ_PREV_UP;
            else alive = 1'b0;
         SEQ_NEXT_DOWN:
            if (sc == {1'b1, next_key}) next_state = SEQ_NEXT_UP;
            else alive = 1'b0;
         SEQ_MENU_DOWN:
            if (sc == {1'b1, menu_key}) next_state = SEQ_MENU_UP;
            else alive = 1'b0;
         default: begin
            case (seq_state)
               SEQ_PREV_UP: cmd_kind = hsr_pkg::KIND_PREV;
               SEQ_NEXT_UP: cmd_kind = hsr_pkg::KIND_NEXT;
               default:     cmd_kind = hsr_pkg::KIND_MENU;
            endcase
            done = (sc == {1'b1, mod_key});
            alive = done;
         end
      endcase
      if (done) begin
         res.kind = cmd_kind;
         res.code = '0;
         res.last = 1'b1;
         expected_results.push_back(res);
         held_count = 0;
         seq_state = SEQ_IDLE;
      end else if (!alive) begin
         // replay everything held, breaking code included
         for (i = 0; i < held_count; i++) begin
            res.kind = hsr_pkg::KIND_FWD;
            res.code = held_codes[i];
            res.last = (i == held_count - 1);
            expected_results.push_back(res);
         end
         held_count = 0;
         seq_state = SEQ_IDLE;
      end else begin
         seq_state = next_state;
      end
   endtask

   task automatic report_field(input string field, input int want, input int got);
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      hotkey_result_type want;
      if (reset) begin
         mod_key = hsr_pkg::MODIFIER_RESET;
         prev_key = hsr_pkg::PREV_KEY_RESET;
         next_key = hsr_pkg::NEXT_KEY_RESET;
         menu_key = hsr_pkg::MENU_KEY_RESET;
         seq_state = SEQ_IDLE;
         held_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: result with nothing expected, actual kind %0d code 0x%0h %s",
                        $time, rsp_kind, rsp_code, rsp_last ? "last" : "not last");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind) report_field("kind", want.kind, rsp_kind);
               if (rsp_code !== want.code) report_field("code", want.code, rsp_code);
               if (rsp_last !== want.last) report_field("last", want.last, rsp_last);
            end
            if (rsp_kind == hsr_pkg::KIND_FWD) forwards_seen++;
            else commands_seen++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hsr_pkg::CSR_MODIFIER: mod_key = csr_data;
               hsr_pkg::CSR_PREV_KEY: prev_key = csr_data;
               hsr_pkg::CSR_NEXT_KEY: next_key = csr_data;
               default:               menu_key = csr_data;
            endcase
         end
         if (req_valid && req_ready) begin
            track_scancode(req_scancode);
            scancodes_seen++;
         end
      end
      pending_results = expected_results.size();
   end

endmodule

[tb/sv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   logic clock = 1'b0;
   logic reset;

   hsr_req_if req_chan();
   hsr_rsp_if rsp_chan();
   hsr_csr_if csr_chan();

   int error_count, pending_results, scancodes_seen, commands_seen, forwards_seen;
   int settings_used;

   logic [hsr_pkg::CODE_W-1:0] code_queue [$];
   logic [hsr_pkg::KEY_W-1:0]  stim_mod, stim_prev, stim_next, stim_menu;
   bit                         long_hold_go;

   always #10 clock = ~clock;

   hotkey_sequence_recognizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   hotkey_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_scancode    (req_chan.scancode),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_kind        (rsp_chan.kind),
      .rsp_code        (rsp_chan.code),
      .rsp_last        (rsp_chan.last),
      .csr_valid       (csr_chan.valid),
      .csr_ready       (csr_chan.ready),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .error_count     (error_count),
      .pending_results (pending_results),
      .scancodes_seen  (scancodes_seen),
      .commands_seen   (commands_seen),
      .forwards_seen   (forwards_seen)
   );

   // code at one step of a hotkey: mod press, key press, key release, mod release
   function automatic logic [hsr_pkg::CODE_W-1:0] hotkey_code(
      input logic [hsr_pkg::KEY_W-1:0] key, input int step);
      case (step)
         0:       return {1'b0, stim_mod};
         1:       return {1'b0, key};
         2:       return {1'b1, key};
         default: return {1'b1, stim_mod};
      endcase
   endfunction

   // break_at of 4 gives the whole hotkey, else bad_code replaces that step
   task automatic queue_hotkey(input logic [hsr_pkg::KEY_W-1:0] key, input int break_at,
                               input logic [hsr_pkg::CODE_W-1:0] bad_code);
      int step;
      for (step = 0; step < break_at && step < 4; step++)
         code_queue.push_back(hotkey_code(key, step));
      if (break_at < 4) code_queue.push_back(bad_code);
   endtask

   task automatic queue_random_traffic(input int amount);
      int                         added, pick, break_at, step;
      logic [hsr_pkg::KEY_W-1:0]  key;
      logic [hsr_pkg::CODE_W-1:0] bad_code;
      added = 0;
      while (added < amount) begin
         pick = $urandom_range(99);
         case ($urandom_range(2))
            0:       key = stim_prev;
            1:       key = stim_next;
            default: key = stim_menu;
         endcase
         if (pick < 25) begin
            code_queue.push_back(hsr_pkg::CODE_W'($urandom_range(255)));
            added++;
         end else if (pick < 35) begin
            // a hotkey code out of its place
            code_queue.push_back(hotkey_code(key, $urandom_range(3)));
            added++;
         end else begin
            break_at = ($urandom_range(99) < 55) ? 4 : $urandom_range(3);
            step = (break_at < 4) ? break_at : 0;
            if ($urandom_range(1) == 1)
               bad_code = hotkey_code(key, step)
                          ^ (hsr_pkg::CODE_W'(1) << $urandom_range(hsr_pkg::CODE_W - 1));
            else
               bad_code = hsr_pkg::CODE_W'($urandom_range(255));
            queue_hotkey(key, break_at, bad_code);
            added += (break_at < 4) ? break_at + 1 : 4;
         end
      end
   endtask

   task automatic drain();
      wait (code_queue.size() == 0);
      @(negedge clock);
      wait (pending_results == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_key(input logic [hsr_pkg::CSR_IDX_W-1:0] index,
                            input logic [hsr_pkg::KEY_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= value;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
   endtask

   // leaves a half-typed hotkey held across the register writes
   task automatic retune(input logic [hsr_pkg::KEY_W-1:0] m, input logic [hsr_pkg::KEY_W-1:0] p,
                         input logic [hsr_pkg::KEY_W-1:0] n, input logic [hsr_pkg::KEY_W-1:0] k);
      queue_hotkey(stim_prev, 2, '0);
      void'(code_queue.pop_back());
      drain();
      write_key(hsr_pkg::CSR_MODIFIER, m);
      write_key(hsr_pkg::CSR_PREV_KEY, p);
      write_key(hsr_pkg::CSR_NEXT_KEY, n);
      write_key(hsr_pkg::CSR_MENU_KEY, k);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      stim_mod = m;
      stim_prev = p;
      stim_next = n;
      stim_menu = k;
      settings_used++;
   endtask

   initial begin : sender
      int burst_left, gap_left;
      burst_left = 1;
      gap_left = 0;
      forever begin
         @(negedge clock);
         if (gap_left > 0 || code_queue.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.valid <= 1'b1;
            req_chan.scancode <= code_queue[0];
            do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
            void'(code_queue.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               gap_left = $urandom_range(6, 1);
               burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(10, 1);
            end
         end
      end
   end

   initial begin : receiver
      rx_pattern_type pattern;
      int             pattern_left, hold_left, tick;
      pattern = RX_ALWAYS;
      pattern_left = 40;
      hold_left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (long_hold_go) begin
            long_hold_go = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (pattern_left <= 0) begin
               pattern = rx_pattern_type'($urandom_range(3));
               pattern_left = $urandom_range(60, 10);
            end
            pattern_left--;
            case (pattern)
               RX_ALWAYS: rsp_chan.ready <= 1'b1;
               RX_COIN:   rsp_chan.ready <= ($urandom_range(1) == 1);
               RX_SPARSE: rsp_chan.ready <= ($urandom_range(3) == 0);
               default:   rsp_chan.ready <= (tick % 5 == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.scancode = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = hsr_pkg::CSR_MODIFIER;
      csr_chan.data = '0;
      long_hold_go = 1'b0;
      settings_used = 1;
      stim_mod = hsr_pkg::MODIFIER_RESET;
      stim_prev = hsr_pkg::PREV_KEY_RESET;
      stim_next = hsr_pkg::NEXT_KEY_RESET;
      stim_menu = hsr_pkg::MENU_KEY_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the three hotkeys with power-on codes
      queue_hotkey(stim_prev, 4, '0);
      queue_hotkey(stim_next, 4, '0);
      queue_hotkey(stim_menu, 4, '0);
      code_queue.push_back(8'h00);
      code_queue.push_back(8'hff);
      // modifier twice: the second one must not restart, so the key press is forwarded
      queue_hotkey(stim_prev, 1, hotkey_code(stim_prev, 0));
      code_queue.push_back(hotkey_code(stim_prev, 1));
      // wrong key released
      queue_hotkey(stim_prev, 2, hotkey_code(stim_next, 2));
      // miss on the final step replays four codes
      queue_hotkey(stim_next, 3, hotkey_code(stim_next, 0));
      // modifier release where a key press belongs
      queue_hotkey(stim_menu, 1, hotkey_code(stim_menu, 3));
      queue_random_traffic(56);
      drain();

      retune(7'h00, 7'h00, 7'h00, 7'h00);
      queue_random_traffic(56);
      drain();

      retune(7'h7f, 7'h7f, 7'h7f, 7'h7f);
      queue_random_traffic(56);
      drain();

      retune(hsr_pkg::KEY_W'($urandom_range(127)), hsr_pkg::KEY_W'($urandom_range(127)),
             hsr_pkg::KEY_W'($urandom_range(127)), hsr_pkg::KEY_W'($urandom_range(127)));
      queue_random_traffic(56);
      // stall the result side long enough to back the block up into its input
      long_hold_go = 1'b1;
      drain();

      retune(hsr_pkg::KEY_W'($urandom_range(127)), hsr_pkg::KEY_W'($urandom_range(127)),
             hsr_pkg::KEY_W'($urandom_range(127)), hsr_pkg::KEY_W'($urandom_range(127)));
      queue_random_traffic(56);
      drain();

      retune(hsr_pkg::MODIFIER_RESET, hsr_pkg::PREV_KEY_RESET,
             hsr_pkg::NEXT_KEY_RESET, hsr_pkg::MENU_KEY_RESET);
      queue_random_traffic(56);
      drain();

      $display("covered %0d scancodes under %0d key settings", scancodes_seen, settings_used);
      $display("saw %0d switch commands and %0d forwarded codes", commands_seen, forwards_seen);
      if (error_count == 0 && pending_results == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #(4_000_000);
      $display("status: fail");
      $finish;
   end

endmodule

[files.f]
src/hsr_pkg.sv
src/hsr_if.sv
src/hsr_ctrl.sv
src/hsr_dpath.sv
src/hotkey_sequence_recognizer.sv
tb/sv/hotkey_checker.sv
tb/sv/testbench.sv
